// ===== rtl/merq_pkg.sv =====
package merq_pkg;

	localparam int MAX_SUBSCRIBERS_DEF = 8;
	localparam int RING_DEPTH_DEF      = 64;
	localparam int MIN_RING_DEF        = 8;
	localparam int PAYLOAD_BITS_DEF    = 64;
	localparam int CMD_DEPTH           = 2;

	typedef enum logic [1:0] {
		ACT_PUBLISH     = 2'd0,
		ACT_SUBSCRIBE   = 2'd1,
		ACT_UNSUBSCRIBE = 2'd2,
		ACT_POLL        = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] event_payload;
		logic [63:0] event_time;
		logic [63:0] now_time;
		logic [31:0] handle;
		logic [15:0] ring_capacity;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] new_handle;
		logic [63:0] out_payload;
		logic [63:0] out_epoch;
		logic [63:0] out_time;
		logic [31:0] overflow_count;
	} out_item_t;

	// Classified command passed from the front part to the back part.
	typedef struct packed {
		action_t     action;
		logic [63:0] payload;
		logic [63:0] stamp;
		logic [31:0] handle;
		logic [15:0] cap;
	} cmd_t;

	// Ring size: at least the minimum, rounded up to a power of two, capped by depth.
	function automatic logic [15:0] size_ring(input logic [15:0] req, input int min_ring,
			input int depth);
		logic [16:0] want;
		logic [16:0] cap;
		want = (req < 16'(min_ring)) ? 17'(min_ring) : {1'b0, req};
		cap = 17'd1;
		for (int k = 0; k < 16; k++) begin
			if (cap < want && (cap << 1) <= 17'(depth))
				cap = cap << 1;
		end
		return cap[15:0];
	endfunction

endpackage

// ===== rtl/merq_front.sv =====
module merq_front #(
	parameter int PAYLOAD_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  merq_pkg::in_item_t in_data,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output merq_pkg::cmd_t     cmd_data
);
	import merq_pkg::*;

	localparam int PW = $clog2(CMD_DEPTH);

	cmd_t            fifo_q [CMD_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;
	cmd_t            cmd_new;
	logic            push, pop;

	always_comb begin
		cmd_new.action  = action_t'(in_data.action);
		cmd_new.payload = in_data.event_payload & ({64{1'b1}} >> (64 - PAYLOAD_BITS));
		cmd_new.stamp   = (in_data.event_time != 64'd0) ? in_data.event_time
			: in_data.now_time;
		cmd_new.handle  = in_data.handle;
		cmd_new.cap     = in_data.ring_capacity;
	end

	assign in_ready  = (count_q != (PW+1)'(CMD_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd_data  = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= cmd_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

// ===== rtl/merq_back.sv =====
module merq_back #(
	parameter int MAX_SUBSCRIBERS = 8,
	parameter int RING_DEPTH      = 64,
	parameter int MIN_RING        = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  merq_pkg::cmd_t      cmd_data,
	output logic                out_valid,
	input  logic                out_ready,
	output merq_pkg::out_item_t out_data
);
	import merq_pkg::*;

	localparam int SW = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
	localparam int RW = $clog2(RING_DEPTH);
	localparam int AW = SW + RW;
	localparam int MEM_SIZE = MAX_SUBSCRIBERS << RW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FIND, ST_PUB, ST_READ, ST_RDATA, ST_OUT
	} state_t;

	typedef struct packed {
		logic [63:0] payload;
		logic [63:0] epoch;
		logic [63:0] stamp;
	} entry_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [63:0]     epoch_q;
	logic [31:0]     hcnt_q;
	logic [MAX_SUBSCRIBERS-1:0] active_q;
	logic [31:0]     handle_q [MAX_SUBSCRIBERS];
	logic [15:0]     cap_q    [MAX_SUBSCRIBERS];
	logic [15:0]     wcnt_q   [MAX_SUBSCRIBERS];
	logic [15:0]     rcnt_q   [MAX_SUBSCRIBERS];
	logic [31:0]     drops_q  [MAX_SUBSCRIBERS];
	logic [SW-1:0]   idx_q;
	logic            found_q;
	out_item_t       res_q;
	out_item_t       find_res;
	entry_t          mem [MEM_SIZE];
	entry_t          rdata_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	entry_t          mem_wdata;

	// Match and free-slot search (priority encoders over the slot flags).
	logic [SW-1:0] hit_idx, free_idx;
	logic          hit_any, free_any;
	always_comb begin
		hit_idx  = '0;
		hit_any  = 1'b0;
		free_idx = '0;
		free_any = 1'b0;
		for (int i = MAX_SUBSCRIBERS - 1; i >= 0; i--) begin
			if (active_q[i] && handle_q[i] == cmd_q.handle) begin
				hit_idx = SW'(i);
				hit_any = 1'b1;
			end
			if (!active_q[i]) begin
				free_idx = SW'(i);
				free_any = 1'b1;
			end
		end
	end

	// Result fields known right after classification.
	always_comb begin
		find_res = '0;
		case (cmd_q.action)
			ACT_PUBLISH: begin
				find_res.ok        = 1'b1;
				find_res.out_epoch = epoch_q + 64'd1;
				find_res.out_time  = cmd_q.stamp;
			end
			ACT_SUBSCRIBE: begin
				if (free_any) begin
					find_res.ok         = 1'b1;
					find_res.new_handle = hcnt_q;
				end
			end
			ACT_UNSUBSCRIBE: begin
				find_res.ok = hit_any;
			end
			default: find_res.ok = 1'b0;
		endcase
	end

	logic [15:0] used;
	assign used      = wcnt_q[idx_q] - rcnt_q[idx_q];
	assign mem_we    = (state_q == ST_PUB) && active_q[idx_q] && (used < cap_q[idx_q]);
	assign mem_waddr = {idx_q, RW'(wcnt_q[idx_q] & (cap_q[idx_q] - 16'd1))};
	assign mem_raddr = {idx_q, RW'(rcnt_q[idx_q] & (cap_q[idx_q] - 16'd1))};
	assign mem_wdata = '{payload: cmd_q.payload, epoch: epoch_q, stamp: cmd_q.stamp};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			epoch_q  <= '0;
			hcnt_q   <= '0;
			active_q <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			for (int i = 0; i < MAX_SUBSCRIBERS; i++) begin
				wcnt_q[i]  <= '0;
				rcnt_q[i]  <= '0;
				drops_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd_data;
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					res_q <= find_res;
					case (cmd_q.action)
						ACT_PUBLISH: begin
							epoch_q         <= epoch_q + 64'd1;
							idx_q           <= '0;
							state_q         <= ST_PUB;
						end
						ACT_SUBSCRIBE: begin
							if (free_any) begin
								active_q[free_idx] <= 1'b1;
								handle_q[free_idx] <= hcnt_q;
								cap_q[free_idx]    <= size_ring(cmd_q.cap, MIN_RING,
									RING_DEPTH);
								wcnt_q[free_idx]   <= '0;
								rcnt_q[free_idx]   <= '0;
								drops_q[free_idx]  <= '0;
								hcnt_q             <= hcnt_q + 32'd1;
							end
							state_q <= ST_OUT;
						end
						ACT_UNSUBSCRIBE: begin
							if (hit_any)
								active_q[hit_idx] <= 1'b0;
							state_q <= ST_OUT;
						end
						default: begin
							idx_q   <= hit_idx;
							found_q <= hit_any;
							state_q <= hit_any ? ST_READ : ST_OUT;
						end
					endcase
				end
				ST_PUB: begin
					// One slot per cycle; the write port is shared by all rings.
					if (active_q[idx_q]) begin
						if (used < cap_q[idx_q])
							wcnt_q[idx_q] <= wcnt_q[idx_q] + 16'd1;
						else if (drops_q[idx_q] != 32'hFFFF_FFFF)
							drops_q[idx_q] <= drops_q[idx_q] + 32'd1;
					end
					if (idx_q == SW'(MAX_SUBSCRIBERS - 1))
						state_q <= ST_OUT;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_READ: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					res_q.overflow_count <= drops_q[idx_q];
					if (found_q && wcnt_q[idx_q] != rcnt_q[idx_q]) begin
						res_q.ok          <= 1'b1;
						res_q.out_payload <= rdata_q.payload;
						res_q.out_epoch   <= rdata_q.epoch;
						res_q.out_time    <= rdata_q.stamp;
						rcnt_q[idx_q]     <= rcnt_q[idx_q] + 16'd1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/multicast_event_ring_queues.sv =====
// Channel  | Signals                     | Direction
// in       | in_valid, in_ready, in_data | item into the block
// out      | out_valid, out_ready, out   | one result per item
//
// In the back part a publish goes through ST_FIND, then ST_PUB once for each slot, as
// the single ring write port visits one slot per cycle, then ST_OUT. Subscribe and
// unsubscribe go from ST_FIND to ST_OUT; poll passes ST_READ for the registered ring
// read and ST_RDATA when the handle is found, and goes from ST_FIND to ST_OUT when not.
// Reset clears slot flags, counters and drop counts at once; ring memory is not cleared.
// A two-entry command queue takes up to two more input transfers while a result is stalled.
module multicast_event_ring_queues #(
	parameter int MAX_SUBSCRIBERS = merq_pkg::MAX_SUBSCRIBERS_DEF,
	parameter int RING_DEPTH      = merq_pkg::RING_DEPTH_DEF,
	parameter int MIN_RING        = merq_pkg::MIN_RING_DEF,
	parameter int PAYLOAD_BITS    = merq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  merq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output merq_pkg::out_item_t out
);
	import merq_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd_data;

	merq_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.cmd_valid, .cmd_ready, .cmd_data
	);

	merq_back #(
		.MAX_SUBSCRIBERS(MAX_SUBSCRIBERS),
		.RING_DEPTH(RING_DEPTH),
		.MIN_RING(MIN_RING)
	) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd_data,
		.out_valid, .out_ready, .out_data(out)
	);

endmodule

// ===== tb/tb_multicast_event_ring_queues.sv =====
module tb_multicast_event_ring_queues;
	import merq_pkg::*;

	localparam int NSLOT = MAX_SUBSCRIBERS_DEF;
	localparam int DEPTH = RING_DEPTH_DEF;
	localparam int MINR  = MIN_RING_DEF;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out;

	multicast_event_ring_queues uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out(out)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Mirror of the block state.
	logic [63:0] epoch_q;
	logic [31:0] next_handle;
	logic        act_q [NSLOT];
	logic [31:0] hdl_q [NSLOT];
	logic [15:0] cap_q [NSLOT];
	logic [15:0] wr_q [NSLOT];
	logic [15:0] rd_q [NSLOT];
	logic [31:0] drops_q [NSLOT];
	logic [63:0] ev_pay [NSLOT*DEPTH];
	logic [63:0] ev_epoch [NSLOT*DEPTH];
	logic [63:0] ev_time [NSLOT*DEPTH];

	in_item_t  pending_items[$];
	out_item_t expected_results[$];
	int        mismatches;
	int        burst_left;
	int        gap_left;
	logic      stall_hold;
	int        stall_phase;
	logic      hold_off;

	function automatic logic [15:0] ring_size(input logic [15:0] req);
		int want;
		int c;
		want = (req < MINR) ? MINR : req;
		c = 1;
		while (c < want && c * 2 <= DEPTH)
			c = c * 2;
		return 16'(c);
	endfunction

	function automatic int lookup_slot(input logic [31:0] h);
		for (int i = 0; i < NSLOT; i++)
			if (act_q[i] && hdl_q[i] == h)
				return i;
		return -1;
	endfunction

	task automatic queue_step(input in_item_t it);
		out_item_t r;
		int s;
		int idx;
		logic [63:0] t;
		logic [15:0] used;
		r = '0;
		case (action_t'(it.action))
			ACT_PUBLISH: begin
				epoch_q = epoch_q + 64'd1;
				t = (it.event_time != 0) ? it.event_time : it.now_time;
				for (int i = 0; i < NSLOT; i++) begin
					if (act_q[i]) begin
						used = wr_q[i] - rd_q[i];
						if (used >= cap_q[i]) begin
							if (drops_q[i] != 32'hFFFF_FFFF)
								drops_q[i]++;
						end else begin
							idx = i * DEPTH + int'(wr_q[i] & (cap_q[i] - 16'd1));
							ev_pay[idx] = it.event_payload;
							ev_epoch[idx] = epoch_q;
							ev_time[idx] = t;
							wr_q[i] = wr_q[i] + 16'd1;
						end
					end
				end
				r.ok = 1'b1;
				r.out_epoch = epoch_q;
				r.out_time = t;
			end
			ACT_SUBSCRIBE: begin
				s = -1;
				for (int i = NSLOT - 1; i >= 0; i--)
					if (!act_q[i])
						s = i;
				if (s >= 0) begin
					act_q[s] = 1'b1;
					hdl_q[s] = next_handle;
					cap_q[s] = ring_size(it.ring_capacity);
					wr_q[s] = '0;
					rd_q[s] = '0;
					drops_q[s] = '0;
					r.new_handle = next_handle;
					next_handle = next_handle + 32'd1;
					r.ok = 1'b1;
				end
			end
			ACT_UNSUBSCRIBE: begin
				s = lookup_slot(it.handle);
				if (s >= 0) begin
					act_q[s] = 1'b0;
					r.ok = 1'b1;
				end
			end
			default: begin
				s = lookup_slot(it.handle);
				if (s >= 0) begin
					r.overflow_count = drops_q[s];
					if (wr_q[s] != rd_q[s]) begin
						idx = s * DEPTH + int'(rd_q[s] & (cap_q[s] - 16'd1));
						r.out_payload = ev_pay[idx];
						r.out_epoch = ev_epoch[idx];
						r.out_time = ev_time[idx];
						rd_q[s] = rd_q[s] + 16'd1;
						r.ok = 1'b1;
					end
				end
			end
		endcase
		expected_results = {expected_results, r};
	endtask

	function automatic in_item_t make_item(input action_t a, input logic [31:0] h,
			input logic [15:0] cap);
		in_item_t it;
		it.action = a;
		it.event_payload = {$urandom, $urandom};
		it.event_time = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
		it.now_time = {$urandom, $urandom};
		it.handle = h;
		it.ring_capacity = cap;
		return it;
	endfunction

	// Handles granted so far, for picking mostly valid handles.
	logic [31:0] granted;

	function automatic logic [31:0] pick_handle();
		if (granted == 0 || $urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, granted - 1);
	endfunction

	function automatic logic [15:0] pick_cap();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 8));
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 70));
		endcase
	endfunction

	initial begin
		in_item_t it;
		epoch_q = '0;
		next_handle = '0;
		granted = '0;
		for (int i = 0; i < NSLOT; i++) begin
			act_q[i] = 1'b0;
			hdl_q[i] = '0;
			cap_q[i] = '0;
			wr_q[i] = '0;
			rd_q[i] = '0;
			drops_q[i] = '0;
		end
		hold_off = 1'b0;
		// Directed: publish with no subscriber, unknown handles, field extremes.
		it = make_item(ACT_PUBLISH, 0, 0);
		it.event_time = '0;
		it.now_time = '1;
		it.event_payload = '1;
		pending_items = {pending_items, it};
		pending_items = {pending_items, make_item(ACT_POLL, 32'hFFFF_FFFF, 0)};
		pending_items = {pending_items, make_item(ACT_UNSUBSCRIBE, 0, 0)};
		pending_items = {pending_items, make_item(ACT_SUBSCRIBE, 0, 16'd0)};
		pending_items = {pending_items, make_item(ACT_SUBSCRIBE, 0, 16'hFFFF)};
		pending_items = {pending_items, make_item(ACT_SUBSCRIBE, 0, 16'd9)};
		pending_items = {pending_items, make_item(ACT_POLL, 0, 0)};
		for (int k = 0; k < 10; k++) begin
			it = make_item(ACT_PUBLISH, 0, 0);
			if (k == 0) begin
				it.event_payload = '0;
				it.event_time = '1;
			end
			pending_items = {pending_items, it};
		end
		pending_items = {pending_items, make_item(ACT_POLL, 0, 0)};
		pending_items = {pending_items, make_item(ACT_POLL, 1, 0)};
		for (int k = 0; k < 6; k++)
			pending_items = {pending_items, make_item(ACT_SUBSCRIBE, 0, 16'd64)};
		pending_items = {pending_items, make_item(ACT_UNSUBSCRIBE, 2, 0)};
		pending_items = {pending_items, make_item(ACT_UNSUBSCRIBE, 2, 0)};
		granted = 32'd9;
		// Random part, weighted so rings fill, drain and overflow.
		for (int k = 0; k < 1130; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: it = make_item(ACT_PUBLISH, pick_handle(), pick_cap());
				4: begin
					it = make_item(ACT_SUBSCRIBE, pick_handle(), pick_cap());
					granted++;
				end
				5: it = make_item(ACT_UNSUBSCRIBE, pick_handle(), pick_cap());
				default: it = make_item(ACT_POLL, pick_handle(), pick_cap());
			endcase
			pending_items = {pending_items, it};
		end
	end

	// Sender: bursts with gaps, plus one full drain pause midway.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				queue_step(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (hold_off && (expected_results.size() != 0 ||
						(in_valid && in_ready))) begin
					in_valid <= 1'b0;
				end else if (pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					if (pending_items.size() == 600)
						hold_off = 1'b1;
					else
						hold_off = 1'b0;
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Receiver: stalls on its own rolling pattern, with stretches of none.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 97;
			if (stall_phase < 30)
				out_ready <= 1'b1;
			else if (stall_phase < 60)
				out_ready <= (stall_phase % 3) != 0;
			else
				out_ready <= $urandom_range(0, 3) == 0;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", out);
			end else begin
				e = expected_results.pop_front();
				if (out !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p actual %p", e, out);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
